/* src/lbmc_pkg.sv */
package lbmc_pkg;

    localparam int DW      = 32;
    localparam int N_DIR   = 9;
    localparam int OMEGA_W = 16;

    localparam logic [OMEGA_W-1:0] RELAX_RESET = 16'd29491;

    // Pipeline depths of the sub-units, in register stages.
    localparam int DIV_LAT    = 34;
    localparam int SQRT_LAT   = 32;
    localparam int EQ_LAT     = 14;
    localparam int EQ_USQ_TAP = 2;

    // Constant divider inside the equilibrium unit: 6 stages of 7 bits.
    localparam int CDIV_W     = 42;
    localparam int CDIV_CHUNK = 7;
    localparam int CDIV_STG   = CDIV_W / CDIV_CHUNK;

    typedef logic [N_DIR-1:0][DW-1:0] t_dvec;

    localparam int DIR_X [N_DIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [N_DIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int MIRROR_OF [N_DIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
    localparam logic [5:0] W_DEN [N_DIR] = '{6'd9, 6'd9, 6'd9, 6'd9, 6'd9,
                                             6'd36, 6'd36, 6'd36, 6'd36};

    typedef struct packed {
        logic [5:0]            rem;
        logic [CDIV_CHUNK-1:0] q;
    } t_dchunk;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic zero;
    } t_div_ctl;

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[DW-1:0];
    endfunction

    // Seven restoring steps of a division by a small constant.
    function automatic t_dchunk div_chunk(input logic [5:0] rem,
                                          input logic [CDIV_CHUNK-1:0] bits,
                                          input logic [5:0] d);
        t_dchunk    res;
        logic [6:0] s;
        res.rem = rem;
        res.q   = '0;
        for (int j = CDIV_CHUNK - 1; j >= 0; j--) begin
            s = {res.rem, bits[j]};
            if (s >= {1'b0, d}) begin
                s = s - {1'b0, d};
                res.q[j] = 1'b1;
            end
            res.rem = s[5:0];
        end
        return res;
    endfunction

endpackage

/* src/lbmc_in_if.sv */
interface lbmc_in_if import lbmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] dens_rest;
    logic signed [DW-1:0] dens_east;
    logic signed [DW-1:0] dens_north;
    logic signed [DW-1:0] dens_west;
    logic signed [DW-1:0] dens_south;
    logic signed [DW-1:0] dens_northeast;
    logic signed [DW-1:0] dens_northwest;
    logic signed [DW-1:0] dens_southwest;
    logic signed [DW-1:0] dens_southeast;
    logic                 is_obstacle;

    modport source (output valid, dens_rest, dens_east, dens_north, dens_west, dens_south,
                    dens_northeast, dens_northwest, dens_southwest, dens_southeast,
                    is_obstacle, input ready);
    modport sink (input valid, dens_rest, dens_east, dens_north, dens_west, dens_south,
                  dens_northeast, dens_northwest, dens_southwest, dens_southeast,
                  is_obstacle, output ready);
endinterface

/* src/lbmc_out_if.sv */
interface lbmc_out_if import lbmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] new_rest;
    logic signed [DW-1:0] new_east;
    logic signed [DW-1:0] new_north;
    logic signed [DW-1:0] new_west;
    logic signed [DW-1:0] new_south;
    logic signed [DW-1:0] new_northeast;
    logic signed [DW-1:0] new_northwest;
    logic signed [DW-1:0] new_southwest;
    logic signed [DW-1:0] new_southeast;
    logic [DW-1:0]        speed_norm;
    logic                 is_fluid;

    modport source (output valid, new_rest, new_east, new_north, new_west, new_south,
                    new_northeast, new_northwest, new_southwest, new_southeast,
                    speed_norm, is_fluid, input ready);
    modport sink (input valid, new_rest, new_east, new_north, new_west, new_south,
                  new_northeast, new_northwest, new_southwest, new_southeast,
                  speed_norm, is_fluid, output ready);
endinterface

/* src/lbmc_delay.sv */
module lbmc_delay import lbmc_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

/* src/lbmc_div.sv */
module lbmc_div import lbmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [34:0]   i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [DW-1:0] o_quo
);
    // Computes sat32((num * 2^24) / den), truncating toward zero; 0 when den is 0.
    // One quotient bit per stage on magnitudes.
    logic [DW-1:0] r_rem [0:DW];
    logic [DW-1:0] r_lo  [0:DW];
    logic [DW-1:0] r_q   [0:DW];
    logic [DW-1:0] r_dm  [0:DW];
    t_div_ctl      r_ctl [0:DW];
    logic signed [DW-1:0] r_quo;

    logic [34:0]   num_mag;
    logic [57:0]   n_nmag;
    logic [DW-1:0] n_dmag;
    t_div_ctl      n_ctl;
    logic [DW-1:0] n_rem [1:DW];
    logic [DW-1:0] n_q   [1:DW];
    logic [32:0]   sh;
    logic signed [DW-1:0] n_quo;

    always_comb begin
        num_mag    = i_num[34] ? 35'(-i_num) : 35'(i_num);
        n_nmag     = {num_mag[33:0], 24'b0};
        n_dmag     = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        n_ctl.neg  = i_num[34] ^ i_den[DW-1];
        n_ctl.ovf  = {6'b0, n_nmag[57:32]} >= n_dmag;
        n_ctl.zero = (i_den == '0);
    end

    always_comb begin
        for (int k = 0; k < DW; k++) begin
            sh = {r_rem[k], r_lo[k][DW-1]};
            if (sh >= {1'b0, r_dm[k]}) begin
                sh = sh - {1'b0, r_dm[k]};
                n_q[k+1] = {r_q[k][DW-2:0], 1'b1};
            end else begin
                n_q[k+1] = {r_q[k][DW-2:0], 1'b0};
            end
            n_rem[k+1] = sh[DW-1:0];
        end
    end

    always_comb begin
        if (r_ctl[DW].zero) begin
            n_quo = '0;
        end else if (!r_ctl[DW].neg) begin
            n_quo = (r_ctl[DW].ovf || r_q[DW][DW-1]) ? 32'sh7fffffff : $signed(r_q[DW]);
        end else if (r_ctl[DW].ovf || r_q[DW] > 32'h80000000) begin
            n_quo = 32'sh80000000;
        end else begin
            n_quo = $signed(DW'(~r_q[DW] + 32'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {6'b0, n_nmag[57:32]};
            r_lo[0]  <= n_nmag[31:0];
            r_q[0]   <= '0;
            r_dm[0]  <= n_dmag;
            r_ctl[0] <= n_ctl;
            for (int k = 1; k <= DW; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_lo[k]  <= {r_lo[k-1][DW-2:0], 1'b0};
                r_dm[k]  <= r_dm[k-1];
                r_ctl[k] <= r_ctl[k-1];
            end
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;
endmodule

/* src/lbmc_sqrt.sv */
module lbmc_sqrt import lbmc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [63:0]   i_rad,
    output logic [DW-1:0] o_root
);
    // Bit-pair restoring square root, one result bit per stage.
    logic [63:0] r_v [SQRT_LAT];
    logic [63:0] r_r [SQRT_LAT];
    logic [63:0] n_v [SQRT_LAT];
    logic [63:0] n_r [SQRT_LAT];
    logic [63:0] v_in, r_in, bitv;
    logic [64:0] trial;

    always_comb begin
        for (int k = 0; k < SQRT_LAT; k++) begin
            v_in  = (k == 0) ? i_rad : r_v[(k == 0) ? 0 : k-1];
            r_in  = (k == 0) ? 64'd0 : r_r[(k == 0) ? 0 : k-1];
            bitv  = 64'd1 << (62 - 2 * k);
            trial = {1'b0, r_in} + {1'b0, bitv};
            if ({1'b0, v_in} >= trial) begin
                n_v[k] = v_in - trial[63:0];
                n_r[k] = (r_in >> 1) + bitv;
            end else begin
                n_v[k] = v_in;
                n_r[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_LAT; k++) begin
                r_v[k] <= n_v[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_root = r_r[SQRT_LAT-1][DW-1:0];
endmodule

/* src/lbmc_equil.sv */
module lbmc_equil import lbmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_ux,
    input  logic signed [DW-1:0] i_uy,
    input  logic signed [DW-1:0] i_rho,
    input  t_dvec                i_f,
    input  logic [OMEGA_W-1:0]   i_omega,
    output logic [63:0]          o_usq48,
    output t_dvec                o_new
);
    // Stage 1: projections e.u and the squared velocity components.
    logic signed [DW-1:0] r1_eu [N_DIR];
    logic [63:0]          r1_ax2, r1_ay2;
    // Stage 2: |u|^2 and (e.u)^2.
    logic [63:0]          r2_usq48;
    logic [63:0]          r2_eusq [N_DIR];
    logic signed [DW-1:0] r2_eu [N_DIR];
    // Stage 3: the bracket of the equilibrium.
    logic signed [DW-1:0] r3_b [N_DIR];
    // Stage 4: rho times bracket.
    logic signed [39:0]   r4_p [N_DIR];
    // Stages 5 to 11: division by 9 or 36.
    logic [CDIV_W-1:0]    r_dm [0:CDIV_STG][N_DIR];
    logic [CDIV_W-1:0]    r_dq [0:CDIV_STG][N_DIR];
    logic [5:0]           r_dr [0:CDIV_STG][N_DIR];
    logic                 r_dn [0:CDIV_STG][N_DIR];
    // Stages 12 to 14: relaxation.
    logic signed [43:0]   r12_delta [N_DIR];
    logic signed [60:0]   r13_prod [N_DIR];
    t_dvec                r14_new;
    logic signed [DW-1:0] r_rho [1:3];
    t_dvec                r_f [1:EQ_LAT-1];

    logic [DW-1:0]        ax, ay, am;
    logic signed [33:0]   ex, ey;
    logic signed [DW-1:0] n1_eu [N_DIR];
    logic [63:0]          n2_eusq [N_DIR];
    logic [45:0]          t9, t3u;
    logic signed [45:0]   e3, bsum;
    logic signed [DW-1:0] n3_b [N_DIR];
    logic signed [63:0]   pr;
    logic signed [39:0]   n4_p [N_DIR];
    logic [39:0]          pm;
    logic [CDIV_W-1:0]    n5_m [N_DIR];
    t_dchunk              ch;
    logic [CDIV_W-1:0]    n_dq [1:CDIV_STG][N_DIR];
    logic [5:0]           n_dr [1:CDIV_STG][N_DIR];
    logic signed [42:0]   feq;
    logic signed [43:0]   n12_delta [N_DIR];
    logic signed [60:0]   n13_prod [N_DIR];
    logic signed [63:0]   rsum;
    t_dvec                n14_new;

    always_comb begin
        ax = i_ux[DW-1] ? DW'(-i_ux) : DW'(i_ux);
        ay = i_uy[DW-1] ? DW'(-i_uy) : DW'(i_uy);
        for (int i = 0; i < N_DIR; i++) begin
            ex = (DIR_X[i] == 1) ? 34'(i_ux) : (DIR_X[i] == -1) ? -34'(i_ux) : 34'sd0;
            ey = (DIR_Y[i] == 1) ? 34'(i_uy) : (DIR_Y[i] == -1) ? -34'(i_uy) : 34'sd0;
            n1_eu[i] = sat32(64'(ex + ey));
        end
    end

    always_comb begin
        for (int i = 0; i < N_DIR; i++) begin
            am = r1_eu[i][DW-1] ? DW'(-r1_eu[i]) : DW'(r1_eu[i]);
            n2_eusq[i] = 64'(am) * 64'(am);
        end
    end

    always_comb begin
        for (int i = 0; i < N_DIR; i++) begin
            t9      = (46'(r2_eusq[i][63:24]) * 46'd9) >> 1;
            t3u     = (46'(r2_usq48[63:24]) * 46'd3) >> 1;
            e3      = 46'(r2_eu[i]) * 46'sd3;
            bsum    = 46'sd16777216 + e3 + $signed(t9) - $signed(t3u);
            n3_b[i] = sat32(64'(bsum));
        end
    end

    always_comb begin
        for (int i = 0; i < N_DIR; i++) begin
            pr      = 64'(r_rho[3]) * 64'(r3_b[i]);
            n4_p[i] = 40'(pr >>> 24);
        end
    end

    // Direction 0 carries weight 4/9: its magnitude enters shifted by two.
    always_comb begin
        for (int i = 0; i < N_DIR; i++) begin
            pm      = r4_p[i][39] ? 40'(-r4_p[i]) : 40'(r4_p[i]);
            n5_m[i] = (i == 0) ? {pm, 2'b00} : {2'b00, pm};
        end
    end

    always_comb begin
        for (int k = 0; k < CDIV_STG; k++) begin
            for (int i = 0; i < N_DIR; i++) begin
                ch = div_chunk(r_dr[k][i],
                               r_dm[k][i][CDIV_W-1-CDIV_CHUNK*k -: CDIV_CHUNK], W_DEN[i]);
                n_dq[k+1][i] = {r_dq[k][i][CDIV_W-CDIV_CHUNK-1:0], ch.q};
                n_dr[k+1][i] = ch.rem;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N_DIR; i++) begin
            feq = r_dn[CDIV_STG][i] ? -$signed({1'b0, r_dq[CDIV_STG][i]})
                                    : $signed({1'b0, r_dq[CDIV_STG][i]});
            n12_delta[i] = 44'(feq) - 44'($signed(r_f[11][i]));
            n13_prod[i]  = 61'(r12_delta[i]) * 61'($signed({1'b0, i_omega}));
            rsum         = 64'($signed(r_f[13][i])) + 64'(r13_prod[i] >>> 14);
            n14_new[i]   = sat32(rsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax2   <= 64'(ax) * 64'(ax);
            r1_ay2   <= 64'(ay) * 64'(ay);
            r2_usq48 <= r1_ax2 + r1_ay2;
            r_rho[1] <= i_rho;
            r_rho[2] <= r_rho[1];
            r_rho[3] <= r_rho[2];
            r_f[1]   <= i_f;
            for (int s = 2; s < EQ_LAT; s++) begin
                r_f[s] <= r_f[s-1];
            end
            for (int i = 0; i < N_DIR; i++) begin
                r1_eu[i]     <= n1_eu[i];
                r2_eu[i]     <= r1_eu[i];
                r2_eusq[i]   <= n2_eusq[i];
                r3_b[i]      <= n3_b[i];
                r4_p[i]      <= n4_p[i];
                r_dm[0][i]   <= n5_m[i];
                r_dq[0][i]   <= '0;
                r_dr[0][i]   <= '0;
                r_dn[0][i]   <= r4_p[i][39];
                for (int k = 1; k <= CDIV_STG; k++) begin
                    r_dm[k][i] <= r_dm[k-1][i];
                    r_dq[k][i] <= n_dq[k][i];
                    r_dr[k][i] <= n_dr[k][i];
                    r_dn[k][i] <= r_dn[k-1][i];
                end
                r12_delta[i] <= n12_delta[i];
                r13_prod[i]  <= n13_prod[i];
            end
            r14_new <= n14_new;
        end
    end

    assign o_usq48 = r2_usq48;
    assign o_new   = r14_new;
endmodule

/* src/lattice_boltzmann_d2q9_cell_collide.sv */
// D2Q9 BGK collision for one lattice cell per item.
//
// i_cell carries the nine streamed densities of a cell (signed Q8.24) and
// its obstacle flag; o_cell returns the nine post-collision densities, the
// velocity magnitude and the fluid flag. Both are valid/ready channels and
// an item moves on a clock edge where valid and ready are both high. The relaxation
// rate omega (unsigned Q2.14) is written through i_cfg_we and i_cfg_wdata; the user
// must do so only while no item is in flight, which the block does not enforce. Reset loads about 1.8.
//
// The datapath is a fixed pipeline of 70 register stages, and one item is
// accepted in every cycle unless the receiver holds off a result. The depth
// is set by the long divider that forms the velocity (34 stages, 32 of them
// with one quotient bit each) followed by the square root of |u|^2 (32
// stages, one root bit each); the equilibrium and relaxation math runs
// beside the square root and waits in a delay line.
//
// When the receiver holds off a result, the whole pipeline freezes and
// i_cell.ready drops, so nothing is lost or repeated. Reset clears every
// valid bit; the payload registers are left as they are.
module lattice_boltzmann_d2q9_cell_collide import lbmc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lbmc_in_if.sink            i_cell,
    lbmc_out_if.source         o_cell,
    input  logic               i_cfg_we,
    input  logic [OMEGA_W-1:0] i_cfg_wdata
);
    // Stage 1 is the moment sum, then divider, then the square root tap of
    // the equilibrium unit plus the root, then the output register.
    localparam int LAT     = 1 + DIV_LAT + EQ_USQ_TAP + SQRT_LAT + 1;
    localparam int NEW_DLY = EQ_USQ_TAP + SQRT_LAT - EQ_LAT;
    localparam int OBS_DLY = EQ_USQ_TAP + SQRT_LAT;
    localparam int D1_W    = N_DIR * DW + DW + 1;
    localparam int D2_W    = N_DIR * DW + 1;

    logic [LAT-1:0]       r_vld;
    logic [OMEGA_W-1:0]   r_omega;
    logic                 pipe_en;

    t_dvec                r_f;
    logic signed [DW-1:0] r_rho;
    logic signed [34:0]   r_mx, r_my;
    logic                 r_obs;

    t_dvec                n_f;
    logic signed [35:0]   sum;
    logic signed [34:0]   n_mx, n_my;

    logic signed [DW-1:0] ux, uy;
    logic [D1_W-1:0]      d1_q;
    t_dvec                f_eq;
    logic signed [DW-1:0] rho_eq;
    logic                 obs_eq;
    logic [63:0]          usq48;
    t_dvec                new_eq, new_dly;
    logic [DW-1:0]        root;
    logic [D2_W-1:0]      d2_q;
    t_dvec                f_out;
    logic                 obs_out;

    t_dvec                r_new, n_new;
    logic [DW-1:0]        r_spd, n_spd;
    logic                 r_fluid, n_fluid;

    // The pipeline moves as one; it holds only when a result is waiting.
    assign pipe_en      = !r_vld[LAT-1] || o_cell.ready;
    assign i_cell.ready = i_rst_n && pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega <= RELAX_RESET;
        end else if (i_cfg_we) begin
            r_omega <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAT-2:0], i_cell.valid};
        end
    end

    // Moments: density sum and the exact x and y momentum.
    always_comb begin
        n_f[0] = i_cell.dens_rest;
        n_f[1] = i_cell.dens_east;
        n_f[2] = i_cell.dens_north;
        n_f[3] = i_cell.dens_west;
        n_f[4] = i_cell.dens_south;
        n_f[5] = i_cell.dens_northeast;
        n_f[6] = i_cell.dens_northwest;
        n_f[7] = i_cell.dens_southwest;
        n_f[8] = i_cell.dens_southeast;
        sum = 36'(i_cell.dens_rest) + 36'(i_cell.dens_east) + 36'(i_cell.dens_north)
            + 36'(i_cell.dens_west) + 36'(i_cell.dens_south) + 36'(i_cell.dens_northeast)
            + 36'(i_cell.dens_northwest) + 36'(i_cell.dens_southwest)
            + 36'(i_cell.dens_southeast);
        n_mx = 35'(i_cell.dens_east) + 35'(i_cell.dens_northeast)
             + 35'(i_cell.dens_southeast) - 35'(i_cell.dens_west)
             - 35'(i_cell.dens_northwest) - 35'(i_cell.dens_southwest);
        n_my = 35'(i_cell.dens_north) + 35'(i_cell.dens_northeast)
             + 35'(i_cell.dens_northwest) - 35'(i_cell.dens_south)
             - 35'(i_cell.dens_southwest) - 35'(i_cell.dens_southeast);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_f   <= n_f;
            r_rho <= sat32(64'(sum));
            r_mx  <= n_mx;
            r_my  <= n_my;
            r_obs <= i_cell.is_obstacle;
        end
    end

    // Velocity, one divider per axis.
    lbmc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_mx),
        .i_den (r_rho),
        .o_quo (ux)
    );

    lbmc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_my),
        .i_den (r_rho),
        .o_quo (uy)
    );

    lbmc_delay #(.WIDTH(D1_W), .DEPTH(DIV_LAT)) u_dly_div (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_d   ({r_f, r_rho, r_obs}),
        .o_q   (d1_q)
    );

    assign f_eq   = d1_q[D1_W-1 -: N_DIR*DW];
    assign rho_eq = $signed(d1_q[DW:1]);
    assign obs_eq = d1_q[0];

    lbmc_equil u_equil (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_ux    (ux),
        .i_uy    (uy),
        .i_rho   (rho_eq),
        .i_f     (f_eq),
        .i_omega (r_omega),
        .o_usq48 (usq48),
        .o_new   (new_eq)
    );

    lbmc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_rad  (usq48),
        .o_root (root)
    );

    lbmc_delay #(.WIDTH(N_DIR*DW), .DEPTH(NEW_DLY)) u_dly_new (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_d   (new_eq),
        .o_q   (new_dly)
    );

    // Inputs and obstacle flag wait for the bounce-back case.
    lbmc_delay #(.WIDTH(D2_W), .DEPTH(OBS_DLY)) u_dly_obs (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_d   ({f_eq, obs_eq}),
        .o_q   (d2_q)
    );

    assign f_out   = d2_q[D2_W-1 -: N_DIR*DW];
    assign obs_out = d2_q[0];

    // Output register: bounce-back for obstacle cells, relaxed values otherwise.
    always_comb begin
        if (obs_out) begin
            for (int i = 0; i < N_DIR; i++) begin
                n_new[i] = f_out[MIRROR_OF[i]];
            end
            n_spd   = '0;
            n_fluid = 1'b0;
        end else begin
            n_new   = new_dly;
            n_spd   = root;
            n_fluid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_new   <= n_new;
            r_spd   <= n_spd;
            r_fluid <= n_fluid;
        end
    end

    assign o_cell.valid          = r_vld[LAT-1];
    assign o_cell.new_rest       = r_new[0];
    assign o_cell.new_east       = r_new[1];
    assign o_cell.new_north      = r_new[2];
    assign o_cell.new_west       = r_new[3];
    assign o_cell.new_south      = r_new[4];
    assign o_cell.new_northeast  = r_new[5];
    assign o_cell.new_northwest  = r_new[6];
    assign o_cell.new_southwest  = r_new[7];
    assign o_cell.new_southeast  = r_new[8];
    assign o_cell.speed_norm     = r_spd;
    assign o_cell.is_fluid       = r_fluid;

    // An obstacle result never reports a speed.
    a_obstacle_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell.valid && !o_cell.is_fluid |-> o_cell.speed_norm == '0)
        else $error("obstacle cell with nonzero speed");

    // The input only stalls because a finished result is being held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cell.ready |-> o_cell.valid && !o_cell.ready)
        else $error("input stalled without output back-pressure");

    // Reset empties the whole pipeline.
    a_reset_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_cell.valid && r_vld == '0)
        else $error("item survived reset");
endmodule

/* sim/tb_lattice_boltzmann_d2q9_cell_collide.sv */
`timescale 1ns / 100ps

module tb_lattice_boltzmann_d2q9_cell_collide;
    import lbmc_pkg::*;

    localparam longint Q_ONE    = 64'sd16777216;
    localparam longint POS_FULL = 64'sd2147483647;
    localparam longint NEG_FULL = -64'sd2147483648;
    // The pipeline is 70 stages deep; leave some margin on top of that.
    localparam int PIPE_SETTLE = 90;

    // One collided cell as the block reports it.
    typedef struct {
        t_dvec         dens;
        logic [DW-1:0] speed;
        logic          fluid;
    } t_cell_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [OMEGA_W-1:0] i_cfg_wdata;

    lbmc_in_if  cell_in ();
    lbmc_out_if cell_out ();

    lattice_boltzmann_d2q9_cell_collide dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (cell_in),
        .o_cell      (cell_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Our own copy of omega, updated whenever the register is written.
    logic [OMEGA_W-1:0] omega_model;
    t_cell_result       pending_cells[$];
    int                 error_count;
    // When set, neither side inserts idle cycles.
    bit                 back_to_back;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL lattice_boltzmann_d2q9_cell_collide");
        $finish;
    end

    function automatic longint clamp32(input longint v);
        if (v > POS_FULL) begin
            return POS_FULL;
        end
        if (v < NEG_FULL) begin
            return NEG_FULL;
        end
        return v;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = v;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rem) begin
            probe = probe >> 2;
        end
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // BGK collision of one cell, or bounce-back for an obstacle.
    function automatic t_cell_result collide_cell(input t_dvec d, input logic obst,
                                                  input logic [OMEGA_W-1:0] om);
        t_cell_result    res;
        longint          f [N_DIR];
        longint          sum, mx, my, rho, ux, uy, usq, eu, eu2, bterm, p, feq, nv;
        longint          om_l;
        longint unsigned usq48, spd, a;
        int              wn;
        for (int i = 0; i < N_DIR; i++) begin
            f[i] = longint'($signed(d[i]));
        end
        if (obst) begin
            // Bounce-back: each direction takes the density of its opposite.
            for (int i = 0; i < N_DIR; i++) begin
                res.dens[i] = d[MIRROR_OF[i]];
            end
            res.speed = '0;
            res.fluid = 1'b0;
            return res;
        end
        om_l = longint'(om);
        sum  = 0;
        for (int i = 0; i < N_DIR; i++) begin
            sum += f[i];
        end
        rho = clamp32(sum);
        mx  = f[1] + f[5] + f[8] - (f[3] + f[6] + f[7]);
        my  = f[2] + f[5] + f[6] - (f[4] + f[7] + f[8]);
        ux  = 0;
        uy  = 0;
        // A cell of zero density is taken as being at rest.
        if (rho != 0) begin
            ux = clamp32((mx * Q_ONE) / rho);
            uy = clamp32((my * Q_ONE) / rho);
        end
        usq48 = magnitude(ux) * magnitude(ux) + magnitude(uy) * magnitude(uy);
        usq   = longint'(usq48 >> 24);
        spd   = int_sqrt(usq48);
        if (spd > 64'hFFFF_FFFF) begin
            spd = 64'hFFFF_FFFF;
        end
        for (int i = 0; i < N_DIR; i++) begin
            eu    = clamp32(DIR_X[i] * ux + DIR_Y[i] * uy);
            a     = magnitude(eu);
            eu2   = longint'((a * a) >> 24);
            bterm = clamp32(Q_ONE + 3 * eu + ((9 * eu2) >>> 1) - ((3 * usq) >>> 1));
            p     = (rho * bterm) >>> 24;
            wn    = (i == 0) ? 4 : 1;
            feq   = (p * wn) / longint'(W_DEN[i]);
            nv    = f[i] + (((feq - f[i]) * om_l) >>> 14);
            res.dens[i] = clamp32(nv);
        end
        res.speed = spd[DW-1:0];
        res.fluid = 1'b1;
        return res;
    endfunction

    // Presents one cell after a random gap (none in back-to-back mode) and waits until it is taken.
    task automatic send_cell(input t_dvec d, input logic obst);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            cell_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_in.dens_rest      <= d[0];
        cell_in.dens_east      <= d[1];
        cell_in.dens_north     <= d[2];
        cell_in.dens_west      <= d[3];
        cell_in.dens_south     <= d[4];
        cell_in.dens_northeast <= d[5];
        cell_in.dens_northwest <= d[6];
        cell_in.dens_southwest <= d[7];
        cell_in.dens_southeast <= d[8];
        cell_in.is_obstacle    <= obst;
        cell_in.valid          <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!cell_in.ready);
        pending_cells.push_back(collide_cell(d, obst, omega_model));
    endtask

    // Waits for the pipeline to empty, then writes omega.
    task automatic write_omega(input logic [OMEGA_W-1:0] value);
        cell_in.valid <= 1'b0;
        while (pending_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        omega_model = value;
    endtask

    function automatic t_dvec uniform_dens();
        t_dvec d;
        for (int i = 0; i < N_DIR; i++) begin
            d[i] = $urandom();
        end
        return d;
    endfunction

    // A cell near equilibrium: positive densities around the lattice weights.
    function automatic t_dvec physical_dens();
        t_dvec d;
        d[0] = 32'd7456540 + $urandom_range(0, 1 << 21);
        for (int i = 1; i < 5; i++) begin
            d[i] = 32'd1864135 + $urandom_range(0, 1 << 20);
        end
        for (int i = 5; i < N_DIR; i++) begin
            d[i] = 32'd466033 + $urandom_range(0, 1 << 18);
        end
        return d;
    endfunction

    function automatic t_dvec fill_dens(input logic [DW-1:0] v);
        t_dvec d;
        for (int i = 0; i < N_DIR; i++) begin
            d[i] = v;
        end
        return d;
    endfunction

    // Receiver: a random stall is drawn after each accepted result.
    initial begin
        int hold;
        hold = 0;
        cell_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && cell_out.valid && cell_out.ready) begin
                hold = back_to_back ? 0 : $urandom_range(0, 17);
            end
            if (hold > 0) begin
                cell_out.ready <= 1'b0;
                hold--;
            end else begin
                cell_out.ready <= 1'b1;
            end
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_cell_result want;
        t_cell_result got;
        if (i_rst_n && cell_out.valid && cell_out.ready) begin
            got.dens  = {cell_out.new_southeast, cell_out.new_southwest,
                         cell_out.new_northwest, cell_out.new_northeast,
                         cell_out.new_south, cell_out.new_west, cell_out.new_north,
                         cell_out.new_east, cell_out.new_rest};
            got.speed = cell_out.speed_norm;
            got.fluid = cell_out.is_fluid;
            if (pending_cells.size() == 0) begin
                $display("%0t: result with no cell outstanding", $time);
                error_count++;
            end else begin
                want = pending_cells.pop_front();
                for (int i = 0; i < N_DIR; i++) begin
                    if (got.dens[i] !== want.dens[i]) begin
                        $display("%0t: density %0d expected %h actual %h",
                                 $time, i, want.dens[i], got.dens[i]);
                        error_count++;
                    end
                end
                if (got.speed !== want.speed) begin
                    $display("%0t: speed_norm expected %h actual %h",
                             $time, want.speed, got.speed);
                    error_count++;
                end
                if (got.fluid !== want.fluid) begin
                    $display("%0t: is_fluid expected %b actual %b",
                             $time, want.fluid, got.fluid);
                    error_count++;
                end
            end
        end
    end

    // Extremes of the fields, obstacle cells, zero and saturated density.
    task automatic test_directed();
        t_dvec d;
        send_cell(fill_dens(32'h7fffffff), 1'b1);
        send_cell(fill_dens(32'h80000000), 1'b1);
        for (int i = 0; i < N_DIR; i++) begin
            d[i] = 32'h1000 * (i + 1);
        end
        send_cell(d, 1'b1);
        // Zero density: velocity is forced to zero.
        send_cell(fill_dens(32'h0), 1'b0);
        d = fill_dens(32'h0);
        d[1] = 32'h01000000;
        d[3] = 32'hff000000;
        send_cell(d, 1'b0);
        // Density sums that saturate in both directions.
        send_cell(fill_dens(32'h7fffffff), 1'b0);
        send_cell(fill_dens(32'h80000000), 1'b0);
        // Large momentum over saturated, then tiny density; the tiny one saturates u.
        d = fill_dens(32'h0);
        d[0] = 32'hff000001;
        d[1] = 32'h7fffffff;
        d[2] = 32'h7fffffff;
        send_cell(d, 1'b0);
        d[0] = 32'h80000000;
        d[1] = 32'h7fffffff;
        d[5] = 32'h7fffffff;
        d[2] = 32'h80000000;
        send_cell(d, 1'b0);
        d = fill_dens(32'h0);
        d[0] = 32'h00000001;
        send_cell(d, 1'b0);
        d[0] = 32'hffffffff;
        send_cell(d, 1'b0);
        // A cell at rest with unit density.
        d[0] = 32'd7456540;
        for (int i = 1; i < 5; i++) d[i] = 32'd1864135;
        for (int i = 5; i < N_DIR; i++) d[i] = 32'd466033;
        send_cell(d, 1'b0);
        for (int i = 0; i < 8; i++) begin
            send_cell(physical_dens(), 1'b0);
        end
        send_cell(uniform_dens(), 1'b0);
        send_cell(uniform_dens(), 1'b1);
    endtask

    // Mostly near-equilibrium cells, with full-range noise and obstacles.
    task automatic run_random_cells(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_cell(physical_dens(), 1'b0);
            end else if (pick < 80) begin
                send_cell(uniform_dens(), 1'b0);
            end else if (pick < 90) begin
                send_cell(uniform_dens(), 1'b1);
            end else begin
                send_cell(fill_dens($urandom_range(0, 3) - 1), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Omega at the bottom, at 2.0, at the top of the register and in between.
    task automatic test_relax_settings();
        logic [OMEGA_W-1:0] settings [5] = '{16'd0, 16'd32768, 16'hffff, 16'd1, 16'd16384};
        foreach (settings[k]) begin
            write_omega(settings[k]);
            test_directed();
            run_random_cells(40);
        end
        write_omega(OMEGA_W'($urandom()));
        run_random_cells(40);
    endtask

    // Long random run with a back-to-back stretch and one full drain.
    task automatic test_random_traffic();
        write_omega(RELAX_RESET);
        back_to_back = 1'b1;
        run_random_cells(150);
        back_to_back = 1'b0;
        run_random_cells(200);
        // Sender holds off until every outstanding result has come back.
        cell_in.valid <= 1'b0;
        while (pending_cells.size() != 0) begin
            @(posedge i_clk);
        end
        run_random_cells(200);
    endtask

    initial begin
        error_count  = 0;
        back_to_back = 1'b0;
        omega_model  = RELAX_RESET;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        cell_in.valid          <= 1'b0;
        cell_in.dens_rest      <= '0;
        cell_in.dens_east      <= '0;
        cell_in.dens_north     <= '0;
        cell_in.dens_west      <= '0;
        cell_in.dens_south     <= '0;
        cell_in.dens_northeast <= '0;
        cell_in.dens_northwest <= '0;
        cell_in.dens_southwest <= '0;
        cell_in.dens_southeast <= '0;
        cell_in.is_obstacle    <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset value of omega first, then the other settings.
        test_directed();
        test_relax_settings();
        test_random_traffic();

        cell_in.valid <= 1'b0;
        while (pending_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS lattice_boltzmann_d2q9_cell_collide");
        end else begin
            $display("FAIL lattice_boltzmann_d2q9_cell_collide");
        end
        $finish;
    end

endmodule
